/* rtl/sbda_pkg.sv */
`default_nettype none

package sbda_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_IDX_W = 4;
    // Wide enough for nine times the largest power of ten
    localparam int CALC_W      = 34;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    localparam logic [CALC_W-1:0] POW10 [MAX_DIGITS] = '{
        34'd1,
        34'd10,
        34'd100,
        34'd1000,
        34'd10000,
        34'd100000,
        34'd1000000,
        34'd10000000,
        34'd100000000,
        34'd1000000000
    };

    // One classified number: sign, position of its leading digit, magnitude
    typedef struct packed {
        logic                   neg;
        logic [DIGIT_IDX_W-1:0] top_pos;
        logic [VALUE_W-1:0]     mag;
    } sbda_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SIGN,
        BK_DIGIT
    } sbda_state_t;

endpackage

`default_nettype wire

/* rtl/signed_binary_to_decimal_ascii_top.sv */
// Signed 32-bit integer to decimal ASCII text. Each transfer on the slave side
// carries one two's complement value; the master side then carries its text one
// character per transfer, most significant digit first, with a leading '-' for
// negative values, no leading zeros, '0' alone for zero, and tlast on the final
// character. The most negative value comes out as -2147483648. The back end's
// pace is set by the digit loop, which produces one digit per cycle while the
// master side does not stall it, into a single-character output register. The
// front end takes the sign, forms the magnitude and finds the leading digit
// position, and a two-entry queue lets it keep taking numbers while the back
// end is still writing out earlier ones. Nothing is kept between numbers.

`default_nettype none

module signed_binary_to_decimal_ascii_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] character
    output logic             m_tlast    // last_char
);
    import sbda_pkg::*;

    // front end to queue
    logic       push_valid;
    logic       push_ready;
    sbda_item_t push_item;

    // queue to back end
    logic       q_valid;
    logic       q_pop;
    sbda_item_t q_item;

    // Sign, magnitude and leading digit position, one stage deep
    sbda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouples intake from character output
    sbda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // Sign character, then one digit per cycle unless stalled, leading first
    sbda_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Only a minus sign or a decimal digit ever leaves the block
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == ASCII_MINUS) ||
                     ((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_ZERO + 8'd9)))
        else $error("illegal character on output");

    // A minus sign is always followed by digits, so it never closes a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata == ASCII_MINUS)) |-> !m_tlast)
        else $error("minus sign flagged as last character");

    // Intake only stalls when the front stage is held up by a full queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (push_valid && !push_ready))
        else $error("input stalled without a full queue");

    // The back end pops only what the queue holds
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/sbda_front.sv */
`default_nettype none

module sbda_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [sbda_pkg::VALUE_W-1:0] s_tdata,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output sbda_pkg::sbda_item_t             push_item
);
    import sbda_pkg::*;

    logic               stg_valid_reg;
    logic               stg_valid_next;
    logic               stg_neg_reg;
    logic [VALUE_W-1:0] stg_mag_reg;
    logic               accept;
    logic [DIGIT_IDX_W-1:0] top_pos;

    assign s_tready   = !stg_valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = stg_valid_reg;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stg_valid_next = 1'b0;
        end
    end

    // Leading digit position: how many powers of ten above one fit in the magnitude
    always_comb
    begin
        top_pos = '0;
        for (int k = 1; k < MAX_DIGITS; k++)
        begin
            if ({{(CALC_W-VALUE_W){1'b0}}, stg_mag_reg} >= POW10[k])
            begin
                top_pos = top_pos + DIGIT_IDX_W'(1);
            end
        end
    end

    assign push_item.neg     = stg_neg_reg;
    assign push_item.top_pos = top_pos;
    assign push_item.mag     = stg_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // Magnitude in unsigned arithmetic: the most negative value maps onto itself
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_neg_reg <= s_tdata[VALUE_W-1];
            stg_mag_reg <= s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
        end
    end

endmodule

`default_nettype wire

/* rtl/sbda_queue.sv */
`default_nettype none

module sbda_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sbda_pkg::sbda_item_t in_item,
    output logic                      out_valid,
    input  wire logic                 out_pop,
    output sbda_pkg::sbda_item_t      out_item
);
    import sbda_pkg::*;

    sbda_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_pop && out_valid;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/sbda_back.sv */
`default_nettype none

module sbda_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire sbda_pkg::sbda_item_t        q_item,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [sbda_pkg::CHAR_W-1:0]      m_tdata,
    output logic                             m_tlast
);
    import sbda_pkg::*;

    sbda_state_t            state_reg;
    sbda_state_t            state_next;
    logic [VALUE_W-1:0]     rem_reg;
    logic [VALUE_W-1:0]     rem_next;
    logic [DIGIT_IDX_W-1:0] pos_reg;
    logic [DIGIT_IDX_W-1:0] pos_next;
    logic                   ovalid_reg;
    logic                   ovalid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   adv;

    logic [CALC_W-1:0]      pow;
    logic [CALC_W-1:0]      thr [MAX_DIGITS];
    logic [DIGIT_IDX_W-1:0] digit;
    logic [CALC_W-1:0]      rem_diff;
    logic [VALUE_W-1:0]     rem_sub;

    // One decimal digit per cycle while the output is not stalled: compare against 1..9 times the current power
    always_comb
    begin
        pow    = POW10[pos_reg];
        thr[0] = '0;
        digit  = '0;
        for (int j = 1; j < MAX_DIGITS; j++)
        begin
            thr[j] = pow * CALC_W'(j);
            if ({{(CALC_W-VALUE_W){1'b0}}, rem_reg} >= thr[j])
            begin
                digit = digit + DIGIT_IDX_W'(1);
            end
        end
        rem_diff = {{(CALC_W-VALUE_W){1'b0}}, rem_reg} - thr[digit];
        rem_sub  = rem_diff[VALUE_W-1:0];
    end

    assign adv = !ovalid_reg || m_tready;

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && !m_tready;
        char_next   = char_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rem_next   = q_item.mag;
                    pos_next   = q_item.top_pos;
                    state_next = q_item.neg ? BK_SIGN : BK_DIGIT;
                end
            end
            BK_SIGN:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    char_next   = ASCII_MINUS;
                    last_next   = 1'b0;
                    state_next  = BK_DIGIT;
                end
            end
            BK_DIGIT:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    char_next   = ASCII_ZERO + {{(CHAR_W-DIGIT_IDX_W){1'b0}}, digit};
                    last_next   = (pos_reg == '0);
                    rem_next    = rem_sub;
                    if (pos_reg == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire
